// ----- hdl/mva_pkg.sv -----
// Package for the MIDI voice allocator: event, command and state types,
// plus the fixed constants shared by the front end, engine and top level.
// No dependencies.
package mva_pkg;

    localparam int NOTES   = 128;
    localparam int MAX_RES = 8;

    localparam logic [1:0] EV_NOTE_ON  = 2'd0;
    localparam logic [1:0] EV_NOTE_OFF = 2'd1;
    localparam logic [1:0] EV_PEDAL    = 2'd2;
    localparam logic [1:0] EV_ALL_OFF  = 2'd3;

    localparam logic [1:0] MODE_LEGATO = 2'd1;
    localparam logic [1:0] MODE_POLY   = 2'd2;

    localparam logic [1:0] STEAL_LOW  = 2'd1;
    localparam logic [1:0] STEAL_HIGH = 2'd2;

    localparam logic CFG_VOICE_MODE = 1'b0;
    localparam logic CFG_STEAL      = 1'b1;

    localparam logic [6:0] VEL_FULL = 7'd127;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_LEGATO = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_MARK   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_ON,
        OP_OFF,
        OP_PEDAL_DN,
        OP_PEDAL_UP,
        OP_ALL_OFF
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] note;
        logic [6:0] vel;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qhead;

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] voice;
        logic [6:0] note;
        logic [6:0] vel;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ON_SET,
        S_SWEEP,
        S_PUSH,
        S_VSEL,
        S_STEAL,
        S_PLAY,
        S_OFF,
        S_REL,
        S_ANY,
        S_TOP_RD,
        S_TOP_VEL,
        S_MONO,
        S_STOP0,
        S_ALLOFF,
        S_DONE
    } t_state;

endpackage

// ----- hdl/mva_front.sv -----
// Front end of the MIDI voice allocator: accepts event beats, classifies
// them into engine operations and holds them in a two-entry queue.
// Depends on mva_pkg.
module mva_front
    import mva_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [6:0] i_note,
    input  logic [6:0] i_velocity,
    input  logic       i_pedal_down,
    output t_qhead     o_head,
    input  logic       i_pop
);

    t_op        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    t_op        n_op;
    logic       push;
    logic       pop;

    always_comb begin
        n_op.note = i_note;
        n_op.vel  = i_velocity;
        unique case (i_mode)
            EV_NOTE_ON:  n_op.kind = OP_ON;
            EV_NOTE_OFF: n_op.kind = OP_OFF;
            EV_PEDAL:    n_op.kind = i_pedal_down ? OP_PEDAL_DN : OP_PEDAL_UP;
            default:     n_op.kind = OP_ALL_OFF;
        endcase
    end

    assign o_ready     = (r_count != 2'd2);
    assign push        = i_valid && o_ready;
    assign pop         = i_pop && (r_count != 2'd0);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.op    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with full count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with empty count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count != 2'd0))
        else $error("queue lost a beat");

endmodule

// ----- hdl/mva_engine.sv -----
// Back end of the MIDI voice allocator: note flags, note stack, voice table
// and the sequencer that turns queued operations into voice command beats.
// Depends on mva_pkg.
module mva_engine
    import mva_pkg::*;
#(
    parameter int NUM_VOICES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_voice_mode,
    input  logic [1:0] i_steal_prio,
    input  t_qhead     i_head,
    output logic       o_pop,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_result    o_res,
    output logic       o_res_last
);

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW = $clog2(NUM_VOICES + 1);

    t_state r_state;
    t_state n_state;

    logic [NOTES-1:0] r_key;
    logic [NOTES-1:0] r_hold;
    logic [NOTES-1:0] r_vok;
    logic [6:0]       mem_stk [NOTES];
    logic [6:0]       mem_vel [NOTES];
    logic [6:0]       r_stk_q;
    logic [6:0]       r_vel_q;
    logic [7:0]       r_cnt;
    logic             r_pedal;

    logic [NUM_VOICES-1:0] r_vact;
    logic [6:0]            r_vnote [NUM_VOICES];
    logic [31:0]           r_vage  [NUM_VOICES];
    logic [31:0]           r_age;

    logic [6:0]    r_note;
    logic [6:0]    r_vel;
    logic          r_rm;
    logic          r_mono;
    logic [7:0]    r_rd;
    logic [7:0]    r_wr;
    logic          r_rdv;
    logic [7:0]    r_idx;
    logic [CW-1:0] r_vi;
    logic [VW-1:0] r_cand;
    logic [6:0]    r_bnote;
    logic [31:0]   r_bage;
    logic          r_any;
    logic [3:0]    r_grp;
    t_cmd          r_pcmd;
    logic [VW-1:0] r_pvoice;
    logic [6:0]    r_pnote;
    logic [6:0]    r_pvel;
    logic [3:0]    r_ecnt;
    t_result       r_pend;
    logic          r_pend_v;
    t_result       r_out;
    logic          r_out_last;
    logic          r_out_v;

    logic          poly;
    logic          legato;
    logic          free_v;
    logic [VW-1:0] free_idx;
    logic [6:0]    fnote;
    logic          found;
    logic [VW-1:0] found_idx;
    logic [VW-1:0] vi;
    logic          vi_live;
    logic          rd_live;
    logic          keep;
    logic          sweep_done;
    logic          better;
    logic [7:0]    grp_bits;
    logic          grp_alive;
    logic [6:0]    rel_n;
    logic          rel;
    logic          em_req;
    t_cmd          em_cmd;
    logic [VW-1:0] em_vidx;
    logic [VW+2:0] em_vext;
    logic [6:0]    em_note;
    t_result       em_res;
    logic          em_take;
    logic          out_free;
    logic          stall;
    logic          go;
    logic          push_now;
    logic          stk_we;
    logic [6:0]    stk_waddr;
    logic [6:0]    stk_wdata;
    logic [6:0]    stk_raddr;
    logic [7:0]    top_addr;

    assign poly   = (i_voice_mode == MODE_POLY);
    assign legato = (i_voice_mode == MODE_LEGATO);

    always_comb begin
        free_v   = 1'b0;
        free_idx = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--) begin
            if (!r_vact[i]) begin
                free_v   = 1'b1;
                free_idx = VW'(i);
            end
        end
    end

    assign fnote = (r_state == S_REL) ? r_idx[6:0] : r_note;

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--) begin
            if (r_vact[i] && (r_vnote[i] == fnote)) begin
                found     = 1'b1;
                found_idx = VW'(i);
            end
        end
    end

    assign vi      = r_vi[VW-1:0];
    assign vi_live = (r_vi < CW'(NUM_VOICES));

    always_comb begin
        case (i_steal_prio)
            STEAL_LOW:  better = (r_vnote[vi] < r_bnote);
            STEAL_HIGH: better = (r_vnote[vi] > r_bnote);
            default:    better = (r_vage[vi] < r_bage);
        endcase
    end

    assign rd_live    = (r_rd < r_cnt);
    assign keep       = r_rm ? (r_stk_q != r_note)
                             : (r_key[r_stk_q] || (r_pedal && r_hold[r_stk_q]));
    assign sweep_done = !rd_live && !r_rdv;

    assign grp_bits  = r_key[{r_grp, 3'b000} +: 8]
                     | ({8{r_pedal}} & r_hold[{r_grp, 3'b000} +: 8]);
    assign grp_alive = |grp_bits;

    assign rel_n = r_idx[6:0];
    assign rel   = !r_idx[7] && r_hold[rel_n] && !r_key[rel_n];

    always_comb begin
        em_req  = 1'b0;
        em_cmd  = CMD_STOP;
        em_vidx = found_idx;
        em_note = fnote;
        em_res.vel = '0;
        unique case (r_state)
            S_PLAY: begin
                em_req     = 1'b1;
                em_cmd     = r_pcmd;
                em_vidx    = r_pvoice;
                em_note    = r_pnote;
                em_res.vel = r_pvel;
            end
            S_OFF: begin
                em_req = poly && found;
                em_cmd = r_pedal ? CMD_MARK : CMD_STOP;
            end
            S_REL: begin
                em_req = rel && poly && found;
            end
            S_STOP0: begin
                em_req  = r_vact[0];
                em_vidx = '0;
                em_note = r_vnote[0];
            end
            S_ALLOFF: begin
                em_req  = vi_live && r_vact[vi];
                em_vidx = vi;
                em_note = r_vnote[vi];
            end
            default: begin
                em_req = 1'b0;
            end
        endcase
        em_vext      = {3'b000, em_vidx};
        em_res.cmd   = em_cmd;
        em_res.voice = em_vext[2:0];
        em_res.note  = em_note;
    end

    assign em_take  = em_req && (r_ecnt < 4'(MAX_RES));
    assign out_free = !r_out_v || i_res_ready;
    assign stall    = em_take && r_pend_v && !out_free;
    assign go       = !stall;
    assign push_now = (em_take && r_pend_v && go)
                   || ((r_state == S_DONE) && r_pend_v && out_free);

    assign o_pop       = (r_state == S_IDLE) && i_head.valid;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;
    assign o_res_last  = r_out_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.op.kind)
                        OP_ON:       n_state = S_ON_SET;
                        OP_OFF:      n_state = S_OFF;
                        OP_PEDAL_DN: n_state = S_DONE;
                        OP_PEDAL_UP: n_state = S_REL;
                        default:     n_state = S_ALLOFF;
                    endcase
                end
            end
            S_ON_SET: n_state = S_SWEEP;
            S_SWEEP: begin
                if (sweep_done) begin
                    if (r_rm) begin
                        n_state = S_PUSH;
                    end else if (!r_mono) begin
                        n_state = S_DONE;
                    end else if (r_wr == 8'd0) begin
                        n_state = S_ANY;
                    end else begin
                        n_state = S_TOP_RD;
                    end
                end
            end
            S_PUSH: n_state = S_VSEL;
            S_VSEL: n_state = (poly && !free_v) ? S_STEAL : S_PLAY;
            S_STEAL: begin
                if (!vi_live) begin
                    n_state = S_PLAY;
                end
            end
            S_PLAY: begin
                if (go) begin
                    n_state = S_DONE;
                end
            end
            S_OFF: begin
                if (go) begin
                    n_state = (!r_pedal && !poly) ? S_SWEEP : S_DONE;
                end
            end
            S_REL: begin
                if (r_idx[7]) begin
                    n_state = S_SWEEP;
                end
            end
            S_ANY: begin
                if (r_grp == 4'hf) begin
                    n_state = (r_any || grp_alive) ? S_DONE : S_STOP0;
                end
            end
            S_TOP_RD:  n_state = S_TOP_VEL;
            S_TOP_VEL: n_state = S_MONO;
            S_MONO:    n_state = S_PLAY;
            S_STOP0: begin
                if (go) begin
                    n_state = S_DONE;
                end
            end
            S_ALLOFF: begin
                if (!vi_live) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_pend_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign top_addr = r_cnt - 8'd1;

    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = r_wr[6:0];
        stk_wdata = r_stk_q;
        stk_raddr = (r_state == S_TOP_RD) ? top_addr[6:0] : r_rd[6:0];
        case (r_state)
            S_SWEEP: begin
                stk_we = r_rdv && keep;
            end
            S_PUSH: begin
                stk_we    = (r_cnt < 8'(NOTES));
                stk_waddr = r_cnt[6:0];
                stk_wdata = r_note;
            end
            default: begin
                stk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stk[stk_waddr] <= stk_wdata;
        end
        r_stk_q <= mem_stk[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ON_SET) begin
            mem_vel[r_note] <= r_vel;
        end
        r_vel_q <= mem_vel[r_stk_q];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_key      <= '0;
            r_hold     <= '0;
            r_vok      <= '0;
            r_cnt      <= '0;
            r_pedal    <= 1'b0;
            r_vact     <= '0;
            r_age      <= 32'd1;
            r_ecnt     <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_rdv      <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_vnote[i] <= '0;
                r_vage[i]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (em_take && go) begin
                r_pend   <= em_res;
                r_pend_v <= 1'b1;
                r_ecnt   <= r_ecnt + 4'd1;
            end else if ((r_state == S_DONE) && out_free) begin
                r_pend_v <= 1'b0;
            end

            if (push_now) begin
                r_out      <= r_pend;
                r_out_last <= (r_state == S_DONE);
                r_out_v    <= 1'b1;
            end else if (i_res_ready) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_ecnt <= '0;
                    r_note <= i_head.op.note;
                    r_vel  <= i_head.op.vel;
                    r_idx  <= '0;
                    r_vi   <= '0;
                    if (i_head.valid) begin
                        case (i_head.op.kind)
                            OP_PEDAL_DN: r_pedal <= 1'b1;
                            OP_PEDAL_UP: r_pedal <= 1'b0;
                            OP_ALL_OFF: begin
                                r_key   <= '0;
                                r_hold  <= '0;
                                r_vok   <= '0;
                                r_cnt   <= '0;
                                r_pedal <= 1'b0;
                            end
                            default: begin
                                r_pedal <= r_pedal;
                            end
                        endcase
                    end
                end
                S_ON_SET: begin
                    r_key[r_note]  <= 1'b1;
                    r_hold[r_note] <= 1'b0;
                    r_vok[r_note]  <= 1'b1;
                    r_rd  <= '0;
                    r_wr  <= '0;
                    r_rdv <= 1'b0;
                    r_rm  <= 1'b1;
                end
                S_SWEEP: begin
                    if (r_rdv && keep) begin
                        r_wr <= r_wr + 8'd1;
                    end
                    if (rd_live) begin
                        r_rd <= r_rd + 8'd1;
                    end
                    r_rdv <= rd_live;
                    if (sweep_done) begin
                        r_cnt <= r_wr;
                        r_grp <= '0;
                        r_any <= 1'b0;
                    end
                end
                S_PUSH: begin
                    if (r_cnt < 8'(NOTES)) begin
                        r_cnt <= r_cnt + 8'd1;
                    end
                end
                S_VSEL: begin
                    r_pnote  <= r_note;
                    r_pvel   <= r_vel;
                    r_pcmd   <= (!poly && legato && r_vact[0]) ? CMD_LEGATO : CMD_START;
                    r_pvoice <= poly ? free_idx : '0;
                    r_cand   <= '0;
                    r_bnote  <= r_vnote[0];
                    r_bage   <= r_vage[0];
                    r_vi     <= CW'(1);
                end
                S_STEAL: begin
                    if (vi_live) begin
                        if (better) begin
                            r_cand  <= vi;
                            r_bnote <= r_vnote[vi];
                            r_bage  <= r_vage[vi];
                        end
                        r_vi <= r_vi + CW'(1);
                    end else begin
                        r_pvoice <= r_cand;
                    end
                end
                S_PLAY: begin
                    if (go) begin
                        r_vact[r_pvoice]  <= 1'b1;
                        r_vnote[r_pvoice] <= r_pnote;
                        r_vage[r_pvoice]  <= r_age;
                        r_age             <= r_age + 32'd1;
                    end
                end
                S_OFF: begin
                    r_key[r_note] <= 1'b0;
                    r_rd   <= '0;
                    r_wr   <= '0;
                    r_rdv  <= 1'b0;
                    r_rm   <= 1'b0;
                    r_mono <= 1'b1;
                    if (r_pedal) begin
                        r_hold[r_note] <= 1'b1;
                    end else if (poly && found && go) begin
                        r_vact[found_idx] <= 1'b0;
                    end
                end
                S_REL: begin
                    r_rd   <= '0;
                    r_wr   <= '0;
                    r_rdv  <= 1'b0;
                    r_rm   <= 1'b0;
                    r_mono <= !poly;
                    if (!r_idx[7] && go) begin
                        if (rel) begin
                            r_hold[rel_n] <= 1'b0;
                            if (poly && found) begin
                                r_vact[found_idx] <= 1'b0;
                            end
                        end
                        r_idx <= r_idx + 8'd1;
                    end
                end
                S_ANY: begin
                    r_any <= r_any || grp_alive;
                    r_grp <= r_grp + 4'd1;
                end
                S_TOP_VEL: begin
                    r_pnote <= r_stk_q;
                end
                S_MONO: begin
                    r_pvel   <= (r_vok[r_pnote] && (r_vel_q != 7'd0)) ? r_vel_q : VEL_FULL;
                    r_pcmd   <= r_vact[0] ? CMD_LEGATO : CMD_START;
                    r_pvoice <= '0;
                end
                S_STOP0: begin
                    if (go) begin
                        r_vact[0] <= 1'b0;
                    end
                end
                S_ALLOFF: begin
                    if (vi_live && go) begin
                        r_vact[vi] <= 1'b0;
                        r_vi       <= r_vi + CW'(1);
                    end
                end
                default: begin
                    r_rdv <= r_rdv;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 8'(NOTES))
        else $error("note stack count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_now |-> out_free)
        else $error("result register overwritten while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= 4'(MAX_RES))
        else $error("too many results for one event");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending result left behind after event");

endmodule

// ----- hdl/midi_voice_allocator_core.sv -----
// MIDI voice allocator, top level. Input channel (i_valid/o_ready) takes one
// event beat: mode, note, velocity, pedal_down. Output channel
// (o_valid/i_ready) gives voice command beats; o_last marks the final beat
// of an event, and an event with no commands gives no beat.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 play mode, 1 steal priority) at the clock edge; write only when idle.
// Events go into a two-entry queue and are run one at a time by the engine.
// An event holds the engine while its passes run. Pedal down runs none;
// pedal release runs a pass over every note, a note stack compaction and,
// in the mono modes with an empty stack, an alive scan over all notes.
// Note on adds a pass over the note stack, and a pass over the voices when
// a voice is stolen. The note stack memory has one read and one write
// port. Each beat is held in a pending register and then in the output
// register.
// A stalled receiver holds the output register; the engine waits on its next
// beat while the queue keeps taking events until full.
// Synchronous reset clears all flags, the stack depth, voices and config; the age
// counter restarts at one. No clearing pass is needed.
module midi_voice_allocator_core
    import mva_pkg::*;
#(
    parameter int NUM_VOICES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [6:0] i_note,
    input  logic [6:0] i_velocity,
    input  logic       i_pedal_down,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_command,
    output logic [2:0] o_voice,
    output logic [6:0] o_out_note,
    output logic [6:0] o_out_velocity,
    output logic       o_last
);

    logic [1:0] r_voice_mode;
    logic [1:0] r_steal_prio;
    t_qhead     head;
    logic       pop;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_mode <= 2'd0;
            r_steal_prio <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOICE_MODE: r_voice_mode <= i_cfg_data;
                default:        r_steal_prio <= i_cfg_data;
            endcase
        end
    end

    mva_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_note       (i_note),
        .i_velocity   (i_velocity),
        .i_pedal_down (i_pedal_down),
        .o_head       (head),
        .i_pop        (pop)
    );

    mva_engine #(
        .NUM_VOICES (NUM_VOICES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_voice_mode (r_voice_mode),
        .i_steal_prio (r_steal_prio),
        .i_head       (head),
        .o_pop        (pop),
        .o_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .o_res        (res),
        .o_res_last   (o_last)
    );

    assign o_command      = res.cmd;
    assign o_voice        = res.voice;
    assign o_out_note     = res.note;
    assign o_out_velocity = res.vel;

endmodule

// ----- tb/mva_checker.sv -----
// Checker for the MIDI voice allocator: watches the config port and both
// channels, predicts the voice command beats of each event and compares them.
// Depends on mva_pkg.
module mva_checker
    import mva_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_mode,
    input  logic [6:0] i_note,
    input  logic [6:0] i_velocity,
    input  logic       i_pedal_down,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_command,
    input  logic [2:0] i_voice,
    input  logic [6:0] i_out_note,
    input  logic [6:0] i_out_velocity,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int VOICES = 8;

    typedef struct {
        t_cmd     cmd;
        bit [2:0] voice;
        bit [6:0] note;
        bit [6:0] vel;
        bit       last;
    } t_cmd_beat;

    t_cmd_beat   beats_due[$];
    t_cmd_beat   event_beats[$];

    bit          key_held   [NOTES];
    bit          pedal_hold [NOTES];
    bit [6:0]    note_vel   [NOTES];
    bit [6:0]    note_stack [NOTES];
    int unsigned stack_depth;
    bit          pedal;
    bit          v_active [VOICES];
    bit [6:0]    v_note   [VOICES];
    bit [31:0]   v_age    [VOICES];
    bit [31:0]   age_ctr;
    bit [1:0]    voice_mode;
    bit [1:0]    steal_rule;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = beats_due.size();

    function automatic void add_beat(t_cmd c, int v, bit [6:0] n, bit [6:0] vl);
        t_cmd_beat b;
        if (event_beats.size() < MAX_RES) begin
            b.cmd = c; b.voice = v[2:0]; b.note = n; b.vel = vl; b.last = 1'b0;
            event_beats.insert(event_beats.size(), b);
        end
    endfunction

    function automatic void stop_voice(int v);
        if (v_active[v]) begin
            add_beat(CMD_STOP, v, v_note[v], 7'd0);
            v_active[v] = 1'b0;
        end
    endfunction

    function automatic void play_voice(int v, t_cmd c, bit [6:0] n, bit [6:0] vl);
        add_beat(c, v, n, vl);
        v_active[v] = 1'b1;
        v_note[v]   = n;
        v_age[v]    = age_ctr;
        age_ctr++;
    endfunction

    function automatic int voice_of(bit [6:0] n);
        for (int i = 0; i < VOICES; i++)
            if (v_active[i] && v_note[i] == n) return i;
        return -1;
    endfunction

    function automatic bit alive(int n);
        return key_held[n] || (pedal && pedal_hold[n]);
    endfunction

    function automatic void stack_drop(bit [6:0] n);
        int unsigned w = 0;
        for (int unsigned r = 0; r < stack_depth; r++)
            if (note_stack[r] != n) note_stack[w++] = note_stack[r];
        stack_depth = w;
    endfunction

    function automatic void stack_prune();
        int unsigned w = 0;
        for (int unsigned r = 0; r < stack_depth; r++)
            if (alive(note_stack[r])) note_stack[w++] = note_stack[r];
        stack_depth = w;
    endfunction

    function automatic void mono_follow();
        bit       any = 0;
        bit [6:0] n;
        stack_prune();
        if (stack_depth == 0) begin
            for (int k = 0; k < NOTES; k++)
                if (alive(k)) any = 1;
            if (!any) stop_voice(0);
        end else begin
            n = note_stack[stack_depth - 1];
            play_voice(0, v_active[0] ? CMD_LEGATO : CMD_START, n,
                       note_vel[n] != 0 ? note_vel[n] : VEL_FULL);
        end
    endfunction

    function automatic int steal_pick();
        int c = 0;
        for (int i = 1; i < VOICES; i++) begin
            if (steal_rule == STEAL_LOW) begin
                if (v_note[i] < v_note[c]) c = i;
            end else if (steal_rule == STEAL_HIGH) begin
                if (v_note[i] > v_note[c]) c = i;
            end else if (v_age[i] < v_age[c]) begin
                c = i;
            end
        end
        return c;
    endfunction

    function automatic void predict_event(bit [1:0] ev, bit [6:0] n, bit [6:0] vl, bit dn);
        bit poly = (voice_mode == MODE_POLY);
        int v;
        event_beats.delete();
        case (ev)
            EV_NOTE_ON: begin
                key_held[n] = 1; pedal_hold[n] = 0; note_vel[n] = vl;
                stack_drop(n);
                if (stack_depth < NOTES) note_stack[stack_depth++] = n;
                if (poly) begin
                    v = -1;
                    for (int i = VOICES - 1; i >= 0; i--)
                        if (!v_active[i]) v = i;
                    if (v < 0) v = steal_pick();
                    play_voice(v, CMD_START, n, vl);
                end else if (voice_mode == MODE_LEGATO && v_active[0]) begin
                    play_voice(0, CMD_LEGATO, n, vl);
                end else begin
                    play_voice(0, CMD_START, n, vl);
                end
            end
            EV_NOTE_OFF: begin
                key_held[n] = 0;
                if (pedal) begin
                    pedal_hold[n] = 1;
                    if (poly) begin
                        v = voice_of(n);
                        if (v >= 0) add_beat(CMD_MARK, v, v_note[v], 7'd0);
                    end
                end else if (poly) begin
                    v = voice_of(n);
                    if (v >= 0) stop_voice(v);
                end else begin
                    stack_drop(n);
                    mono_follow();
                end
            end
            EV_PEDAL: begin
                pedal = dn;
                if (!dn) begin
                    for (int k = 0; k < NOTES; k++)
                        if (pedal_hold[k] && !key_held[k]) begin
                            pedal_hold[k] = 0;
                            if (poly) begin
                                v = voice_of(k[6:0]);
                                if (v >= 0) stop_voice(v);
                            end
                        end
                    stack_prune();
                    if (!poly) mono_follow();
                end
            end
            default: begin
                for (int i = 0; i < VOICES; i++) stop_voice(i);
                for (int k = 0; k < NOTES; k++) begin
                    key_held[k] = 0; pedal_hold[k] = 0; note_vel[k] = 0;
                end
                stack_depth = 0;
                pedal = 0;
            end
        endcase
        if (event_beats.size() > 0) event_beats[event_beats.size() - 1].last = 1'b1;
        foreach (event_beats[i]) beats_due.insert(beats_due.size(), event_beats[i]);
    endfunction

    always @(posedge i_clk) begin
        t_cmd_beat e;
        if (!i_rst_n) begin
            for (int k = 0; k < NOTES; k++) begin
                key_held[k] = 0; pedal_hold[k] = 0; note_vel[k] = 0;
            end
            for (int i = 0; i < VOICES; i++) begin
                v_active[i] = 0; v_note[i] = 0; v_age[i] = 0;
            end
            stack_depth = 0; pedal = 0; age_ctr = 1;
            voice_mode = 0; steal_rule = 0;
            beats_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_VOICE_MODE) voice_mode = i_cfg_data;
                else steal_rule = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                predict_event(i_mode, i_note, i_velocity, i_pedal_down);
            if (i_out_valid && i_out_ready) begin
                if (beats_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected beat: cmd %0d voice %0d note %0d ",
                                 i_command, i_voice, i_out_note,
                                 "vel %0d last %0d", i_out_velocity, i_last);
                end else begin
                    e = beats_due.pop_front();
                    if (i_command !== e.cmd || i_voice !== e.voice || i_out_note !== e.note ||
                        i_out_velocity !== e.vel || i_last !== e.last) begin
                        fails++;
                        if (fails <= 10)
                            $display("beat mismatch: exp cmd %0d voice %0d note %0d ",
                                     e.cmd, e.voice, e.note,
                                     "vel %0d last %0d, ", e.vel, e.last,
                                     "got cmd %0d voice %0d note %0d ",
                                     i_command, i_voice, i_out_note,
                                     "vel %0d last %0d", i_out_velocity, i_last);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/midi_voice_allocator_core_tb.sv -----
// Testbench top for midi_voice_allocator_core: drives config writes and MIDI
// event beats with bursty timing and a stalling receiver; mva_checker judges.
// Depends on mva_pkg, midi_voice_allocator_core and mva_checker.
module midi_voice_allocator_core_tb;
    import mva_pkg::*;

    localparam logic [1:0] MODE_MONO   = 2'd0;
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] STEAL_OLD   = 2'd0;
    localparam logic [1:0] STEAL_SPARE = 2'd3;
    localparam int         DRAIN       = 1000;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_cfg_we = 0;
    logic       i_cfg_idx = 0;
    logic [1:0] i_cfg_data = 0;
    logic       i_valid = 0;
    logic       o_ready;
    logic [1:0] i_mode = 0;
    logic [6:0] i_note = 0;
    logic [6:0] i_velocity = 0;
    logic       i_pedal_down = 0;
    logic       o_valid;
    logic       i_ready = 0;
    logic [1:0] o_command;
    logic [2:0] o_voice;
    logic [6:0] o_out_note;
    logic [6:0] o_out_velocity;
    logic       o_last;
    int         fail_count;
    int         pending;
    int         events_sent = 0;
    int         burst_left = 0;
    bit         held_off = 0;
    logic [6:0] pool_base = 7'd60;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    midi_voice_allocator_core DUT (.*);

    mva_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_mode(i_mode), .i_note(i_note), .i_velocity(i_velocity),
        .i_pedal_down(i_pedal_down), .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_command(o_command), .i_voice(o_voice), .i_out_note(o_out_note),
        .i_out_velocity(o_out_velocity), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    task automatic send_event(logic [1:0] m, logic [6:0] n, logic [6:0] v, logic p);
        i_valid <= 1; i_mode <= m; i_note <= n; i_velocity <= v; i_pedal_down <= p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        events_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 8);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [1:0] data);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_event();
        int       r = $urandom_range(0, 99);
        logic [6:0] n = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127))
                                                      : pool_base + 7'($urandom_range(0, 11));
        if (r < 45)      send_event(EV_NOTE_ON, n, 7'($urandom_range(0, 127)), 1'($urandom));
        else if (r < 82) send_event(EV_NOTE_OFF, n, 7'($urandom_range(0, 127)), 1'($urandom));
        else if (r < 97) send_event(EV_PEDAL, n, 7'($urandom_range(0, 127)), 1'($urandom));
        else             send_event(EV_ALL_OFF, n, 7'($urandom_range(0, 127)), 1'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (!held_off && events_sent >= 120) begin
            i_ready <= 0;
            repeat (1500) @(posedge i_clk);
            held_off = 1;
        end else begin
            case ((events_sent / 20) % 3)
                0: i_ready <= 1;
                1: i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        logic [1:0] modes  [8] = '{MODE_MONO, MODE_LEGATO, MODE_POLY, MODE_POLY,
                                   MODE_POLY, MODE_SPARE, MODE_POLY, MODE_LEGATO};
        logic [1:0] steals [8] = '{STEAL_OLD, STEAL_OLD, STEAL_OLD, STEAL_LOW,
                                   STEAL_HIGH, STEAL_SPARE, STEAL_SPARE, STEAL_HIGH};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        write_cfg(CFG_VOICE_MODE, MODE_MONO);
        write_cfg(CFG_STEAL, STEAL_OLD);
        send_event(EV_NOTE_ON, 7'd0, 7'd0, 1'b0);
        send_event(EV_NOTE_ON, 7'd127, 7'd127, 1'b1);
        send_event(EV_NOTE_OFF, 7'd127, 7'd0, 1'b0);
        send_event(EV_NOTE_ON, 7'd85, 7'd42, 1'b0);
        send_event(EV_PEDAL, 7'd0, 7'd0, 1'b1);
        send_event(EV_NOTE_OFF, 7'd85, 7'd0, 1'b0);
        send_event(EV_NOTE_OFF, 7'd0, 7'd0, 1'b0);
        send_event(EV_PEDAL, 7'd0, 7'd0, 1'b0);
        send_event(EV_NOTE_OFF, 7'd42, 7'd0, 1'b0);
        send_event(EV_ALL_OFF, 7'd127, 7'd127, 1'b1);
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_cfg(CFG_VOICE_MODE, modes[p]);
            write_cfg(CFG_STEAL, steals[p]);
            pool_base = 7'($urandom_range(0, 116));
            if (modes[p] == MODE_POLY) begin
                for (int k = 0; k < 12; k++)
                    send_event(EV_NOTE_ON, pool_base + 7'(k), 7'($urandom_range(0, 127)), 1'b0);
                send_event(EV_PEDAL, 7'd0, 7'd0, 1'b1);
                for (int k = 0; k < 6; k++)
                    send_event(EV_NOTE_OFF, pool_base + 7'(k), 7'd0, 1'b0);
                send_event(EV_PEDAL, 7'd0, 7'd0, 1'b0);
            end
            for (int k = 0; k < 29; k++) random_event();
            send_event(EV_ALL_OFF, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 1'b0);
        end
        wait_idle();
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mva_pkg.sv
hdl/mva_front.sv
hdl/mva_engine.sv
hdl/midi_voice_allocator_core.sv
tb/mva_checker.sv
tb/midi_voice_allocator_core_tb.sv
